/* src/assert_macros.svh */
// Assertion macros used by the decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/pidec_pkg.sv */
// Types, constants and codes of the palette indexed pixel decoder.
package pidec_pkg;

  localparam int unsigned PaletteDepth = 256;
  localparam int unsigned IdxW  = $clog2(PaletteDepth);
  localparam int unsigned SizeW = $clog2(PaletteDepth + 1);
  localparam int unsigned CmpW  = (SizeW > 8) ? SizeW : 8;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StCount = 2'd1,
    StSize  = 2'd2,
    StIndex = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    PhCntLo = 5'b00001,
    PhCntHi = 5'b00010,
    PhPalLo = 5'b00100,
    PhPalHi = 5'b01000,
    PhPix   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] frame_length;
    logic        last_byte;
  } in_word_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    status_e     status;
    logic        last_of_frame;
  } out_word_t;

  // Result waiting for the palette read data.
  typedef struct packed {
    status_e status;
    logic    last;
    logic    pix;
  } res_t;

endpackage

/* src/pidec_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module pidec_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/palette_indexed_pixel_decoder.sv */
// Top level of the palette indexed pixel decoder: frame parser, palette store and output stage.
//
// Usage. The input channel (in_valid_i / in_ready_o / in_data_i) carries one payload byte
// per word, with the frame's declared length and a last-byte mark. A frame starts with a
// little-endian 16-bit palette count, then that many little-endian RGB565 palette words,
// then one index byte per pixel. Each index byte gives one output word (out_valid_o /
// out_ready_i / out_data_o) holding the palette colour. The count, the frame length and
// every index are checked; the first failure gives one error word with a zero colour and
// the last-of-frame mark, after which bytes are dropped up to and including the marked
// last byte. The configuration channel is always ready and writes frame_width (index 0) and
// frame_height (index 1); the user must write it only while the decoder is idle (unchecked).
//
// Throughput is one byte per cycle while the read stage is not stalled. After its byte is
// accepted, a pixel word passes through the synchronous palette read and then the output register.
// Header and palette bytes give no output word and pass without occupying the pipeline.
// When the receiver stalls, one result waits in the output register and one more in the
// read stage; input is still taken while the read stage is free.
// Reset returns the parser to the palette count and sets width and height to one. The
// palette RAM is not cleared: entries are only read after the current frame writes them.
`include "assert_macros.svh"

module palette_indexed_pixel_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pidec_pkg::in_word_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pidec_pkg::out_word_t                out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pidec_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [15:0]                         cfg_data_i
);

  // Configuration registers and the pixel total derived from them. The product is
  // registered with each write so that the size check never has a multiplier in its path.
  logic [15:0] width_q, height_q;
  logic [31:0] pixels_q;

  // Parser state.
  pidec_pkg::phase_e           phase_q, phase_d;
  logic [pidec_pkg::SizeW-1:0] size_q, size_d;
  logic [pidec_pkg::SizeW-1:0] ecnt_q, ecnt_d;
  logic [31:0]                 pcnt_q, pcnt_d;
  logic [7:0]                  low_q, low_d;
  logic                        dropping_q, dropping_d;
  // Frame length taken on the first byte, and the pixel total taken with the palette count.
  logic [31:0]                 len_q, len_d;
  logic [31:0]                 total_q, total_d;

  // Read stage and output register.
  logic                  a_valid_q;
  pidec_pkg::res_t       a_q;
  logic                  out_valid_q;
  pidec_pkg::out_word_t  out_q;
  logic                  a_move;
  logic                  in_fire;

  // Result produced by the current byte.
  logic                  res_valid;
  pidec_pkg::res_t       res;

  // Palette RAM ports.
  logic                       ram_we, ram_re;
  logic [15:0]                ram_rdata;

  logic [15:0]                count;
  logic [31:0]                done;
  logic [pidec_pkg::SizeW-1:0] ecnt_inc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 16'd1;
      height_q <= 16'd1;
      pixels_q <= 32'd1;
    end else begin
      if (cfg_valid_i && (cfg_index_i == pidec_pkg::CfgFrameWidth)) begin
        width_q  <= cfg_data_i;
        pixels_q <= 32'(cfg_data_i) * 32'(height_q);
      end
      if (cfg_valid_i && (cfg_index_i == pidec_pkg::CfgFrameHeight)) begin
        height_q <= cfg_data_i;
        pixels_q <= 32'(width_q) * 32'(cfg_data_i);
      end
    end
  end

  // The read stage advances whenever the output register is free or being emptied.
  assign a_move     = a_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !a_valid_q || a_move;
  assign in_fire    = in_valid_i && in_ready_o;

  assign count    = {in_data_i.data_byte, low_q};
  assign done     = pcnt_q + 32'd1;
  assign ecnt_inc = ecnt_q + pidec_pkg::SizeW'(1);

  always_comb begin
    phase_d    = phase_q;
    size_d     = size_q;
    ecnt_d     = ecnt_q;
    pcnt_d     = pcnt_q;
    low_d      = low_q;
    dropping_d = dropping_q;
    len_d      = len_q;
    total_d    = total_q;
    res_valid  = 1'b0;
    res        = '{status: pidec_pkg::StOk, last: 1'b0, pix: 1'b0};
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    if (in_fire) begin
      if (dropping_q) begin
        if (in_data_i.last_byte) begin
          dropping_d = 1'b0;
          phase_d    = pidec_pkg::PhCntLo;
        end
      end else begin
        case (phase_q)
          pidec_pkg::PhCntLo: begin
            low_d = in_data_i.data_byte;
            len_d = in_data_i.frame_length;
            if (in_data_i.last_byte) begin
              res_valid  = 1'b1;
              res.status = pidec_pkg::StSize;
            end else begin
              phase_d = pidec_pkg::PhCntHi;
            end
          end
          pidec_pkg::PhCntHi: begin
            // The frame size is sampled here, together with the complete palette count.
            if ((count == 16'd0) || (count > 16'(pidec_pkg::PaletteDepth))) begin
              res_valid  = 1'b1;
              res.status = pidec_pkg::StCount;
            end else if ((pixels_q == 32'd0) ||
                         ({2'b00, len_q} !=
                          (34'd2 + {17'd0, count, 1'b0} + {2'b00, pixels_q})) ||
                         in_data_i.last_byte) begin
              res_valid  = 1'b1;
              res.status = pidec_pkg::StSize;
            end else begin
              size_d  = count[pidec_pkg::SizeW-1:0];
              total_d = pixels_q;
              ecnt_d  = '0;
              pcnt_d  = 32'd0;
              phase_d = pidec_pkg::PhPalLo;
            end
          end
          pidec_pkg::PhPalLo: begin
            low_d = in_data_i.data_byte;
            if (in_data_i.last_byte) begin
              res_valid  = 1'b1;
              res.status = pidec_pkg::StSize;
            end else begin
              phase_d = pidec_pkg::PhPalHi;
            end
          end
          pidec_pkg::PhPalHi: begin
            ram_we = 1'b1;
            ecnt_d = ecnt_inc;
            if (in_data_i.last_byte) begin
              res_valid  = 1'b1;
              res.status = pidec_pkg::StSize;
            end else if (ecnt_inc >= size_q) begin
              phase_d = pidec_pkg::PhPix;
            end else begin
              phase_d = pidec_pkg::PhPalLo;
            end
          end
          pidec_pkg::PhPix: begin
            if (in_data_i.last_byte && (done < total_q)) begin
              res_valid  = 1'b1;
              res.status = pidec_pkg::StSize;
            end else if (pidec_pkg::CmpW'(in_data_i.data_byte) >=
                         pidec_pkg::CmpW'(size_q)) begin
              res_valid  = 1'b1;
              res.status = pidec_pkg::StIndex;
            end else begin
              ram_re    = 1'b1;
              pcnt_d    = done;
              res_valid = 1'b1;
              res.pix   = 1'b1;
              if (done >= total_q) begin
                res.last = 1'b1;
                phase_d  = pidec_pkg::PhCntLo;
              end
            end
          end
          default: begin
            phase_d = pidec_pkg::PhCntLo;
          end
        endcase

        // Any failure ends the frame and drops the rest unless this byte was the last.
        if (res_valid && !res.pix) begin
          res.last   = 1'b1;
          phase_d    = pidec_pkg::PhCntLo;
          dropping_d = !in_data_i.last_byte;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= pidec_pkg::PhCntLo;
      size_q      <= '0;
      ecnt_q      <= '0;
      pcnt_q      <= 32'd0;
      low_q       <= 8'd0;
      dropping_q  <= 1'b0;
      len_q       <= 32'd0;
      total_q     <= 32'd0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      size_q     <= size_d;
      ecnt_q     <= ecnt_d;
      pcnt_q     <= pcnt_d;
      low_q      <= low_d;
      dropping_q <= dropping_d;
      len_q      <= len_d;
      total_q    <= total_d;
      if (res_valid) begin
        a_valid_q <= 1'b1;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (a_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers of the two result stages.
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      a_q <= res;
    end
    if (a_move) begin
      out_q.pixel_color   <= a_q.pix ? ram_rdata : 16'd0;
      out_q.status        <= a_q.status;
      out_q.last_of_frame <= a_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Palette store. Writes fill entries in order during the palette phase; reads only
  // happen in the pixel phase, so a read never meets a write to the same entry. The
  // read data holds while the read stage is stalled, because no byte is taken then.
  pidec_ram #(
    .Width (16),
    .Depth (pidec_pkg::PaletteDepth)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ecnt_q[pidec_pkg::IdxW-1:0]),
    .wdata_i ({in_data_i.data_byte, low_q}),
    .re_i    (ram_re),
    .raddr_i (in_data_i.data_byte[pidec_pkg::IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  `ASSERT_NEVER(a_rw_same_cycle, clk_i, rst_ni, ram_we && ram_re,
                "palette read and write in the same cycle")
  `ASSERT_CLK(a_pix_has_palette, clk_i, rst_ni,
              (phase_q == pidec_pkg::PhPix) |-> (size_q != '0),
              "pixel phase entered with an empty palette")
  `ASSERT_CLK(a_fill_in_range, clk_i, rst_ni,
              ((phase_q == pidec_pkg::PhPalLo) || (phase_q == pidec_pkg::PhPalHi)) |->
              (ecnt_q < size_q),
              "palette fill ran past the palette count")
  `ASSERT_CLK(a_stall_holds, clk_i, rst_ni,
              (a_valid_q && !a_move) |=>
              (a_valid_q && $stable(a_q) && (!a_q.pix || $stable(ram_rdata))),
              "stalled read stage lost its result")
  `ASSERT_CLK(a_error_ends_frame, clk_i, rst_ni,
              (out_valid_o && (out_data_o.status != pidec_pkg::StOk)) |->
              (out_data_o.last_of_frame && (out_data_o.pixel_color == 16'd0)),
              "error word without frame end mark or with a colour")

endmodule
